FILE: hw/rtl/sitda_pkg.sv
package sitda_pkg;

  // Default width of the signed input value
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Magnitude bits folded into the BCD register per conversion cycle
  localparam int unsigned BITS_PER_STEP = 4;

  // ASCII codes
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } sitda_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // capture sign and magnitude, clear BCD
    logic conv_step;   // fold BITS_PER_STEP magnitude bits into BCD
    logic skip_shift;  // drop a leading zero digit
    logic digit_shift; // advance to the next digit after a transfer
    logic emit_sign;   // present '-' instead of a digit
  } sitda_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic conv_last;   // current conversion step is the final one
    logic top_zero;    // most significant remaining digit is zero
    logic single_left; // only one digit remains
    logic negative;    // captured value was negative
  } sitda_status_t;

endpackage

FILE: hw/rtl/sitda_if.sv
interface sitda_in_if #(
  parameter int unsigned VALUE_BITS = sitda_pkg::VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitda_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink   (input valid, input character, input last_char, output ready);
endinterface

FILE: hw/rtl/sitda_ctrl.sv
module sitda_ctrl
  import sitda_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  sitda_status_t status_i,
  output sitda_cmd_t    cmd_o
);

  sitda_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.conv_step = 1'b1;
        if (status_i.conv_last) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (status_i.top_zero && !status_i.single_left) begin
          cmd_o.skip_shift = 1'b1;
        end else if (status_i.negative) begin
          state_d = ST_SIGN;
        end else begin
          state_d = ST_DIGIT;
        end
      end
      ST_SIGN: begin
        out_valid_o     = 1'b1;
        cmd_o.emit_sign = 1'b1;
        if (out_ready_i) begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.digit_shift = 1'b1;
          if (status_i.single_left) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Accepted input always starts a conversion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_CONV)
    else $error("input transaction did not start conversion");

  // Final digit transaction returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIGIT && out_ready_i && status_i.single_left |=> state_q == ST_IDLE)
    else $error("run did not end after final digit");

  // Sign is only shown for negative values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SIGN |-> status_i.negative)
    else $error("sign emitted for non-negative value");

endmodule

FILE: hw/rtl/sitda_dpath.sv
module sitda_dpath
  import sitda_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sitda_cmd_t                   cmd_i,
  output sitda_status_t                status_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic [7:0]                   character_o,
  output logic                         last_char_o
);

  // Magnitude padded to whole conversion steps
  localparam int unsigned STEPS  = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int unsigned MAG_W  = STEPS * BITS_PER_STEP;
  localparam int unsigned STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  // Decimal digits of 2^VALUE_BITS, from log10(2) ~ 1233/4096; enough for 2^(VALUE_BITS-1)
  localparam int unsigned NDIG   = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int unsigned BCD_W  = NDIG * 4;
  localparam int unsigned CNT_W  = $clog2(NDIG + 1);

  logic [MAG_W-1:0]      mag_q, mag_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d;
  logic                  neg_q;
  logic [STEP_W-1:0]     step_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [VALUE_BITS-1:0] abs_val;
  logic [3:0]            top_digit;

  // Absolute value; the most negative value maps to 2^(VALUE_BITS-1)
  always_comb begin
    if (value_i[VALUE_BITS-1]) begin
      abs_val = VALUE_BITS'(~value_i) + VALUE_BITS'(1);
    end else begin
      abs_val = VALUE_BITS'(value_i);
    end
  end

  // Shift-and-add-3 over BITS_PER_STEP magnitude bits
  always_comb begin
    bcd_d = bcd_q;
    mag_d = mag_q;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_d[d*4 +: 4] >= 4'd5) begin
          bcd_d[d*4 +: 4] = bcd_d[d*4 +: 4] + 4'd3;
        end
      end
      bcd_d = {bcd_d[BCD_W-2:0], mag_d[MAG_W-1]};
      mag_d = {mag_d[MAG_W-2:0], 1'b0};
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= MAG_W'(abs_val);
      bcd_q <= '0;
      neg_q <= value_i[VALUE_BITS-1];
    end else if (cmd_i.conv_step) begin
      mag_q <= mag_d;
      bcd_q <= bcd_d;
    end else if (cmd_i.skip_shift || cmd_i.digit_shift) begin
      bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
    end
  end

  // Step and digit counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.load) begin
      step_q <= '0;
      cnt_q  <= CNT_W'(NDIG);
    end else begin
      if (cmd_i.conv_step) begin
        step_q <= step_q + STEP_W'(1);
      end
      if (cmd_i.skip_shift || cmd_i.digit_shift) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  assign top_digit = bcd_q[BCD_W-1 -: 4];

  assign status_o.conv_last   = (step_q == STEP_W'(STEPS - 1));
  assign status_o.top_zero    = (top_digit == 4'd0);
  assign status_o.single_left = (cnt_q == CNT_W'(1));
  assign status_o.negative    = neg_q;

  // Output payload
  assign character_o = cmd_i.emit_sign ? ASCII_MINUS : (ASCII_ZERO + 8'(top_digit));
  assign last_char_o = !cmd_i.emit_sign && (cnt_q == CNT_W'(1));

  // Every digit sent is a decimal digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.digit_shift |-> top_digit <= 4'd9)
    else $error("non-decimal digit emitted");

  // Leading zero drop never removes a nonzero digit or the last one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.skip_shift |-> top_digit == 4'd0 && cnt_q > CNT_W'(1))
    else $error("leading zero drop removed a significant digit");

endmodule

FILE: hw/rtl/signed_int_to_decimal_ascii_unit.sv
// Channel  Dir  Payload                          Moves
// in_i     in   value[VALUE_BITS-1:0], signed    one integer per transaction
// out_o    out  character[7:0], last_char        one ASCII character per transaction
//
// An item is taken only when the unit is idle; the unit then runs ceil(VALUE_BITS/4) steps
// of the shift-and-add-3 loop, drops leading zero digits while keeping at least one,
// sends a '-' for negative values and then one character per digit, and returns to idle
// before it takes the next input transaction.
// The output payload is decoded from registered state and holds while out_o.ready is low.
// Reset (rst_ni low, asynchronous) returns the controller to idle; no data is kept.
module signed_int_to_decimal_ascii_unit
  import sitda_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  sitda_in_if.sink       in_i,
  sitda_out_if.source    out_o
);

  sitda_cmd_t    cmd;
  sitda_status_t status;

  // Sequencing
  sitda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Conversion and character datapath
  sitda_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .value_i     (in_i.value),
    .character_o (out_o.character),
    .last_char_o (out_o.last_char)
  );

endmodule
